>>> design/chfm_pkg.sv
// ----------------------------------------------------------------------------
// chfm_pkg
// Shared types and constants for the compass heading CORDIC.
// ----------------------------------------------------------------------------
package chfm_pkg;

  // Vector components: sample * 2^16, grown by the CORDIC gain and the
  // quarter-turn swap of the most negative sample.
  localparam int VecW   = 35;
  // Angle accumulator: degrees (scale 180/3.14159) with 16 fraction bits.
  localparam int AngW   = 26;
  localparam int FracW  = 16;
  localparam int DegW   = 9;
  localparam int TabLen = 24;

  localparam logic signed [AngW-1:0] QuarterTurn = AngW'(5898245);
  localparam logic signed [AngW-1:0] HalfTurn    = AngW'(11796490);
  localparam logic signed [AngW-1:0] FullTurn    = AngW'(23592960);
  localparam logic [AngW-FracW-1:0]  MaxDeg      = (AngW-FracW)'(359);

  // atan(2^-i) in file-scale degrees, 16 fraction bits, rounded to nearest.
  localparam logic signed [AngW-1:0] StageAngle [0:TabLen-1] = '{
    AngW'(2949122), AngW'(1740969), AngW'(919880), AngW'(466945),
    AngW'(234379),  AngW'(117304),  AngW'(58666),  AngW'(29335),
    AngW'(14668),   AngW'(7334),    AngW'(3667),   AngW'(1833),
    AngW'(917),     AngW'(458),     AngW'(229),    AngW'(115),
    AngW'(57),      AngW'(29),      AngW'(14),     AngW'(7),
    AngW'(4),       AngW'(2),       AngW'(1),      AngW'(0)
  };

  // Word handed from one cell to the next.
  typedef struct packed {
    logic                   valid;
    logic                   fixed;  // axis or zero case, angle already final
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [AngW-1:0] z;
  } cell_word_t;

endpackage

>>> design/chfm_prerot.sv
// ----------------------------------------------------------------------------
// chfm_prerot
// Input cell: joins the sample bytes, settles the axis cases and turns a
// left half plane vector into the right half plane.
// ----------------------------------------------------------------------------
module chfm_prerot
  import chfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] x_high,
  input  logic [7:0] x_low,
  input  logic [7:0] y_high,
  input  logic [7:0] y_low,
  output cell_word_t out_word
);

  logic signed [15:0]     x;
  logic signed [15:0]     y;
  logic signed [VecW-1:0] vx0;
  logic signed [VecW-1:0] vy0;
  cell_word_t             word_next;

  assign x   = {x_high, x_low};
  assign y   = {y_high, y_low};
  assign vx0 = {{(VecW-32){x[15]}}, x, 16'b0};
  assign vy0 = {{(VecW-32){y[15]}}, y, 16'b0};

  always_comb begin
    word_next       = '0;
    word_next.valid = in_valid;
    word_next.vx    = vx0;
    word_next.vy    = vy0;
    if (y == 16'sd0) begin
      word_next.fixed = 1'b1;
      word_next.z     = x[15] ? HalfTurn : '0;
    end else if (x == 16'sd0) begin
      word_next.fixed = 1'b1;
      word_next.z     = y[15] ? -QuarterTurn : QuarterTurn;
    end else if (x[15]) begin
      if (!y[15]) begin
        word_next.vx = vy0;
        word_next.vy = -vx0;
        word_next.z  = QuarterTurn;
      end else begin
        word_next.vx = -vy0;
        word_next.vy = vx0;
        word_next.z  = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word.valid <= word_next.valid;
    end
    if (en) begin
      out_word.fixed <= word_next.fixed;
      out_word.vx    <= word_next.vx;
      out_word.vy    <= word_next.vy;
      out_word.z     <= word_next.z;
    end
  end

endmodule

>>> design/chfm_cell.sv
// ----------------------------------------------------------------------------
// chfm_cell
// One vectoring CORDIC micro-rotation with its own register.
// ----------------------------------------------------------------------------
module chfm_cell
  import chfm_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  cell_word_t in_word,
  output cell_word_t out_word
);

  logic signed [VecW-1:0] dx;
  logic signed [VecW-1:0] dy;
  cell_word_t             word_next;

  // Arithmetic shift rounds toward minus infinity.
  assign dx = in_word.vy >>> STAGE;
  assign dy = in_word.vx >>> STAGE;

  always_comb begin
    word_next = in_word;
    if (!in_word.fixed) begin
      if (!in_word.vy[VecW-1]) begin
        word_next.vx = in_word.vx + dx;
        word_next.vy = in_word.vy - dy;
        word_next.z  = in_word.z + StageAngle[STAGE];
      end else begin
        word_next.vx = in_word.vx - dx;
        word_next.vy = in_word.vy + dy;
        word_next.z  = in_word.z - StageAngle[STAGE];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word.valid <= word_next.valid;
    end
    if (en) begin
      out_word.fixed <= word_next.fixed;
      out_word.vx    <= word_next.vx;
      out_word.vy    <= word_next.vy;
      out_word.z     <= word_next.z;
    end
  end

endmodule

>>> design/chfm_finish.sv
// ----------------------------------------------------------------------------
// chfm_finish
// Output cell: wraps a negative angle, keeps whole degrees and saturates.
// ----------------------------------------------------------------------------
module chfm_finish
  import chfm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cell_word_t      in_word,
  output logic            out_valid,
  output logic [DegW-1:0] heading_deg
);

  logic signed [AngW-1:0]    z_wrap;
  logic [AngW-FracW-1:0]     deg_whole;
  logic [DegW-1:0]           deg_next;

  always_comb begin
    z_wrap = in_word.z;
    if (z_wrap[AngW-1]) begin
      z_wrap = z_wrap + FullTurn;
    end
    if (z_wrap[AngW-1]) begin
      z_wrap = '0;
    end
    deg_whole = z_wrap[AngW-1:FracW];
    if (deg_whole > MaxDeg) begin
      deg_next = DegW'(MaxDeg);
    end else begin
      deg_next = deg_whole[DegW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_word.valid;
    end
    if (en) begin
      heading_deg <= deg_next;
    end
  end

endmodule

>>> design/compass_heading_from_magnetometer_unit.sv
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_unit
// Heading in whole degrees from one magnetometer X/Y sample, by a chain of
// CORDIC cells.
//
// Channel   Dir  Bits  Contents
// s_axis    in   32    x_high, x_low, y_high, y_low (x_high in bits 7:0)
// m_axis    out  16    heading_deg in [8:0], zero above
//
// One word enters per cycle while the chain is not held. A result passes
// through the input cell, one cell per CORDIC stage and the output cell.
// When the output word is not taken the whole chain holds, and s_axis_tready
// follows it; empty slots in the chain are not squeezed out while it holds.
// Reset clears the valid flags of every cell.
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer_unit
  import chfm_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_high, x_low, y_high, y_low
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // heading_deg, zero fill
);

  logic            en;
  logic [DegW-1:0] heading_deg;
  cell_word_t      chain [0:CORDIC_STAGES];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  chfm_prerot u_prerot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .x_high   (s_axis_tdata[7:0]),
    .x_low    (s_axis_tdata[15:8]),
    .y_high   (s_axis_tdata[23:16]),
    .y_low    (s_axis_tdata[31:24]),
    .out_word (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    chfm_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_word  (chain[i]),
      .out_word (chain[i+1])
    );
  end

  chfm_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_word     (chain[CORDIC_STAGES]),
    .out_valid   (m_axis_tvalid),
    .heading_deg (heading_deg)
  );

  assign m_axis_tdata = {{(16-DegW){1'b0}}, heading_deg};

endmodule

>>> sim/compass_heading_from_magnetometer_unit_tb.sv
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_unit_tb
// Drives magnetometer X/Y samples into the heading unit and checks every
// heading word against a bit-accurate CORDIC predictor kept in the bench.
// Directed axis, zero and full-scale samples come first, then random ones,
// with bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer_unit_tb;

  localparam int STAGES      = 16;
  localparam int ARC_LEN     = 24;
  localparam int RANDOM_CNT  = 1100;
  localparam int DRAIN_EVERY = 400;
  localparam int TAIL_CYCLES = STAGES + 24;
  localparam int CYCLE_LIMIT = 400000;

  localparam longint QUARTER_Q16 = 64'sd5898245;
  localparam longint FULL_Q16    = 64'sd23592960;
  localparam longint TOP_DEG     = 64'sd359;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // x_high, x_low, y_high, y_low
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // heading_deg, zero fill

  // atan(2^-i) in degrees of scale 180/3.14159, 16 fraction bits.
  longint arc_q16 [0:ARC_LEN-1] = '{
    2949122, 1740969, 919880, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [31:0] words_q [$];
  logic [8:0]  heading_q [$];

  int cycle_count = 0;
  int fail_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int loaded_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic s_took = 1'b0;

  compass_heading_from_magnetometer_unit #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [8:0] predict_heading(logic [31:0] word);
    longint x, y, vx, vy, z, dx, dy, t, deg;
    x = longint'(shortint'({word[7:0], word[15:8]}));
    y = longint'(shortint'({word[23:16], word[31:24]}));
    z = 0;
    if (y == 0) begin
      z = (x < 0) ? 2 * QUARTER_Q16 : 0;
    end else if (x == 0) begin
      z = (y > 0) ? QUARTER_Q16 : -QUARTER_Q16;
    end else begin
      vx = x * 65536;
      vy = y * 65536;
      // Left half plane: turn a quarter toward positive X first.
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx = vy;
          vy = -t;
          z = QUARTER_Q16;
        end else begin
          vx = -vy;
          vy = t;
          z = -QUARTER_Q16;
        end
      end
      for (int i = 0; i < STAGES && i < ARC_LEN; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          z = z + arc_q16[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          z = z - arc_q16[i];
        end
      end
    end
    if (z < 0) z = z + FULL_Q16;
    if (z < 0) z = 0;
    deg = z >>> 16;
    if (deg > TOP_DEG) deg = TOP_DEG;
    return deg[8:0];
  endfunction

  task automatic add_sample(int x, int y);
    logic [15:0] xw, yw;
    xw = x[15:0];
    yw = y[15:0];
    words_q.push_back({yw[7:0], yw[15:8], xw[7:0], xw[15:8]});
  endtask

  function automatic int pick_axis();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        return int'(shortint'($urandom_range(0, 65535)));
      end
      4, 5: begin
        return $urandom_range(0, 16) - 8;
      end
      6: begin
        return int'(shortint'($urandom_range(0, 65535))) >>> $urandom_range(1, 14);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // Sender: bursts of words separated by random gaps, with a periodic
  // hold until every outstanding heading has come back.
  always @(negedge clk) begin : sender
    logic        next_valid;
    logic [31:0] next_data;
    next_valid = s_axis_tvalid;
    next_data = s_axis_tdata;
    if (!rst && !(s_axis_tvalid && !s_took)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (loaded_count > 0 && loaded_count % DRAIN_EVERY == 0 &&
                   heading_q.size() != 0) begin
        next_valid = 1'b0;
      end else if (words_q.size() != 0) begin
        next_data = words_q.pop_front();
        next_valid = 1'b1;
        loaded_count = loaded_count + 1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata <= next_data;
  end

  // Receiver: stall pattern switches between always ready, coin flip and
  // mostly stalled.
  always @(negedge clk) begin : receiver
    logic ready_next;
    ready_next = 1'b1;
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 250);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_RANDOM: ready_next = 1'($urandom_range(0, 1));
      STALL_HEAVY:  ready_next = ($urandom_range(0, 7) == 0);
      default:      ready_next = 1'b1;
    endcase
    m_axis_tready <= ready_next;
  end

  always @(posedge clk) begin : monitor
    logic [8:0] want;
    s_took <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        heading_q.push_back(predict_heading(s_axis_tdata));
        accepted_count = accepted_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (heading_q.size() == 0) begin
          $error("unexpected word: heading_deg actual %0d", m_axis_tdata[8:0]);
          fail_count = fail_count + 1;
        end else begin
          want = heading_q.pop_front();
          checked_count = checked_count + 1;
          if (m_axis_tdata[8:0] !== want) begin
            $error("heading_deg mismatch: expected %0d actual %0d",
                   want, m_axis_tdata[8:0]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    int x, y;
    // Axes, zero vector and full-scale corners.
    add_sample(0, 0);
    add_sample(1, 0);
    add_sample(32767, 0);
    add_sample(-1, 0);
    add_sample(-32768, 0);
    add_sample(0, 1);
    add_sample(0, 32767);
    add_sample(0, -1);
    add_sample(0, -32768);
    // One per quadrant, then the extreme diagonals.
    add_sample(1, 1);
    add_sample(-1, 1);
    add_sample(-1, -1);
    add_sample(1, -1);
    add_sample(32767, 32767);
    add_sample(-32768, -32768);
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    // Just either side of the negative X axis and just below the positive
    // X axis, where the wrap and the upper limit matter.
    add_sample(-32768, -1);
    add_sample(-32768, 1);
    add_sample(32767, -1);
    add_sample(1000, -1);
    add_sample(-5, 3);
    add_sample(3, -5);
    for (int n = 0; n < RANDOM_CNT; n++) begin
      x = pick_axis();
      y = pick_axis();
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(100, 32767);
        y = -int'($urandom_range(1, 3));
      end
      add_sample(x, y);
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (words_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (heading_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples (axes, zero vector, full scale, wrap region, random)",
             accepted_count);
    $display("and checked %0d headings under bursty input and output stalls.",
             checked_count);
    if (fail_count == 0 && heading_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
